### rtl/pdlc_pkg.sv
// ----------------------------------------------------------------------------
// pdlc_pkg
// Types and constants shared by the panel dimming level controller.
// ----------------------------------------------------------------------------
package pdlc_pkg;

   localparam int NUM_LEVELS = 25;
   localparam int SEL_PER_RUN = 4;

   localparam logic [4:0] BOOT_LEVEL = 5'd10;

   // ELVSS and ACL level bounds
   localparam logic [4:0] ELVSS_ACL_LOW_MAX = 5'd14;
   localparam logic [4:0] ELVSS_GRP0_MAX = 5'd4;
   localparam logic [4:0] ELVSS_GRP1_MAX = 5'd10;
   localparam logic [4:0] ELVSS_GRP2_MAX = 5'd14;
   localparam logic [4:0] ACL_OFF_MAX = 5'd1;
   localparam logic [4:0] ACL_FORTY_MAX = 5'd19;

   localparam logic [1:0] CSR_GAMMA_CURVE = 2'd0;
   localparam logic [1:0] CSR_ACL_EN = 2'd1;

   // lowest brightness of levels 1 to 24
   localparam logic [7:0] LEVEL_FLOOR [NUM_LEVELS-1] = '{
      8'd30, 8'd35, 8'd45, 8'd55, 8'd65, 8'd75, 8'd84, 8'd94,
      8'd104, 8'd114, 8'd123, 8'd133, 8'd143, 8'd153, 8'd163, 8'd172,
      8'd182, 8'd192, 8'd202, 8'd211, 8'd221, 8'd231, 8'd241, 8'd251
   };

   typedef enum logic [2:0] {
      KIND_GAMMA22 = 3'd0,
      KIND_GAMMA19 = 3'd1,
      KIND_ELVSS = 3'd2,
      KIND_ACL_ON = 3'd3,
      KIND_ACL_STEP = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ACL_OFF = 2'd0,
      ACL_FORTY = 2'd1,
      ACL_FIFTY = 2'd2
   } acl_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic force_update;
   } req_type;

   typedef struct packed {
      logic [2:0] table_kind;
      logic [4:0] table_index;
      logic last_of_run;
   } rsp_type;

   typedef struct packed {
      logic gamma_curve;
      logic acl_en;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      logic [4:0] index;
   } sel_type;

   typedef struct packed {
      logic [1:0] last_pos;
      sel_type [SEL_PER_RUN-1:0] sel;
   } desc_type;

   function automatic logic [4:0] quantize(input logic [7:0] b);
      logic [4:0] lvl;
      lvl = '0;
      for (int i = 0; i < NUM_LEVELS - 1; i++) begin
         if (b >= LEVEL_FLOOR[i]) begin
            lvl = 5'(i + 1);
         end
      end
      return lvl;
   endfunction

endpackage

### rtl/pdlc_front.sv
// ----------------------------------------------------------------------------
// pdlc_front
// Quantizes a brightness item, drops unforced repeats of the level and builds
// the run of table selections; keeps the applied level and the ACL step state.
// ----------------------------------------------------------------------------
module pdlc_front
   import pdlc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_fire,
   input  req_type  req_payload,
   output logic     push,
   output desc_type push_desc
);

   logic [4:0] applied_level_ff, applied_level_in;
   acl_type acl_state_ff, acl_state_in;

   always_comb begin
      logic [4:0] lvl;
      logic [2:0] n;
      logic [1:0] elvss;
      acl_type target;
      desc_type d;

      lvl = quantize(req_payload.brightness);
      d = '0;
      n = 3'd0;
      target = ACL_OFF;
      acl_state_in = acl_state_ff;

      d.sel[0].kind = cfg.gamma_curve ? KIND_GAMMA19 : KIND_GAMMA22;
      d.sel[0].index = lvl;

      if (cfg.acl_en) begin
         elvss = (lvl <= ELVSS_ACL_LOW_MAX) ? 2'd0 : 2'd1;
      end else if (lvl <= ELVSS_GRP0_MAX) begin
         elvss = 2'd0;
      end else if (lvl <= ELVSS_GRP1_MAX) begin
         elvss = 2'd1;
      end else if (lvl <= ELVSS_GRP2_MAX) begin
         elvss = 2'd2;
      end else begin
         elvss = 2'd3;
      end
      d.sel[1].kind = KIND_ELVSS;
      d.sel[1].index = 5'(elvss);
      n = 3'd2;

      if (cfg.acl_en) begin
         if (acl_state_ff == ACL_OFF) begin
            if (lvl <= ACL_OFF_MAX) begin
               d.sel[2].kind = KIND_ACL_STEP;
            end else begin
               d.sel[2].kind = KIND_ACL_ON;
            end
            d.sel[2].index = '0;
            n = 3'd3;
         end
         if (lvl <= ACL_OFF_MAX) begin
            target = ACL_OFF;
         end else if (lvl <= ACL_FORTY_MAX) begin
            target = ACL_FORTY;
         end else begin
            target = ACL_FIFTY;
         end
         if (acl_state_ff != target) begin
            d.sel[n[1:0]].kind = KIND_ACL_STEP;
            d.sel[n[1:0]].index = 5'(target);
            n = n + 3'd1;
         end
         acl_state_in = target;
      end else begin
         d.sel[2].kind = KIND_ACL_STEP;
         d.sel[2].index = 5'(ACL_OFF);
         n = 3'd3;
         acl_state_in = ACL_OFF;
      end

      d.last_pos = 2'(n - 3'd1);
      push_desc = d;
      push = req_fire && ((lvl != applied_level_ff) || req_payload.force_update);
      applied_level_in = lvl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_level_ff <= BOOT_LEVEL;
         acl_state_ff <= ACL_OFF;
      end else if (push) begin
         applied_level_ff <= applied_level_in;
         acl_state_ff <= acl_state_in;
      end
   end

endmodule

### rtl/pdlc_queue.sv
// ----------------------------------------------------------------------------
// pdlc_queue
// Two-entry queue of selection runs between the front and the back.
// ----------------------------------------------------------------------------
module pdlc_queue
   import pdlc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output desc_type head_desc
);

   desc_type mem [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_desc = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

### rtl/pdlc_back.sv
// ----------------------------------------------------------------------------
// pdlc_back
// Takes runs from the queue and sends their selections one per cycle, while
// the receiver does not stall, through the result register.
// ----------------------------------------------------------------------------
module pdlc_back
   import pdlc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_not_empty,
   input  desc_type q_head_desc,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   logic act_valid_ff, act_valid_in;
   desc_type act_desc_ff, act_desc_in;
   logic [1:0] act_pos_ff, act_pos_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic load_out;
   logic is_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      load_out = act_valid_ff && (!rsp_valid_ff || !rsp_stall);
      is_last = (act_pos_ff == act_desc_ff.last_pos);
      pop = q_not_empty && (!act_valid_ff || (load_out && is_last));

      rsp_in.table_kind = act_desc_ff.sel[act_pos_ff].kind;
      rsp_in.table_index = act_desc_ff.sel[act_pos_ff].index;
      rsp_in.last_of_run = is_last;

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      act_valid_in = act_valid_ff;
      act_desc_in = act_desc_ff;
      act_pos_in = act_pos_ff;
      if (pop) begin
         act_valid_in = 1'b1;
         act_desc_in = q_head_desc;
         act_pos_in = '0;
      end else if (load_out) begin
         act_pos_in = act_pos_ff + 2'd1;
         if (is_last) begin
            act_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_desc_ff <= act_desc_in;
      act_pos_ff <= act_pos_in;
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_valid_ff <= act_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/panel_dimming_level_controller.sv
// ----------------------------------------------------------------------------
// panel_dimming_level_controller
// Maps brightness items onto dimming levels and emits runs of panel
// command-table selections.
//
// req channel: one item per brightness request; accepted on req_valid with
// req_stall low. req_stall rises only while the two-entry run queue is full.
// rsp channel: each non-dropped item yields a run of 2 to 4 selections, the
// final one flagged with last_of_run. An item with unchanged level and no
// force yields no selections.
// Throughput: one selection per cycle at the result register while the
// receiver does not stall; items are taken in consecutive cycles while the
// queue has room.
// Receiver stall holds the result register; the queue absorbs up to two runs
// before req_stall rises.
// Reset: applied level 10, ACL state off, both configuration registers 0.
// User must write configuration via csr_* only while block is idle; unchecked.
// ----------------------------------------------------------------------------
module panel_dimming_level_controller
   import pdlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic       csr_wr_data
);

   cfg_type cfg_ff, cfg_in;
   logic req_fire;
   logic push;
   desc_type push_desc;
   logic pop;
   logic q_full;
   logic q_not_empty;
   desc_type q_head_desc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAMMA_CURVE: cfg_in.gamma_curve = csr_wr_data;
            CSR_ACL_EN:      cfg_in.acl_en = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign req_fire = req_valid && !req_stall;

   pdlc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .push        (push),
      .push_desc   (push_desc)
   );

   pdlc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_desc (q_head_desc)
   );

   pdlc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head_desc (q_head_desc),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// panel dimming level controller testbench
// Drives brightness items and checks each emitted table selection in order
// against a cycle-free model of the level, ELVSS and ACL table choices. Both
// channels idle and stall at random, and the gamma curve and ACL enable
// registers are swept between phases while the block is quiet.
// ----------------------------------------------------------------------------
module testbench;
   import pdlc_pkg::*;

   localparam logic [1:0] CSR_RESERVED = 2'd2;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   class selection_checker;
      logic [4:0] applied_level;
      acl_type acl_state;
      logic gamma_curve;
      logic acl_en;
      rsp_type expected_selections[$];
      int errors;

      function new();
         applied_level = BOOT_LEVEL;
         acl_state = ACL_OFF;
         gamma_curve = 1'b0;
         acl_en = 1'b0;
         errors = 0;
      endfunction

      function void set_register(logic [1:0] index, logic data);
         case (index)
            CSR_GAMMA_CURVE: gamma_curve = data;
            CSR_ACL_EN: acl_en = data;
            default: ;
         endcase
      endfunction

      function logic [4:0] level_of(logic [7:0] bright);
         logic [4:0] lvl;
         lvl = '0;
         for (int i = 0; i < NUM_LEVELS - 1; i++) begin
            if (bright >= LEVEL_FLOOR[i]) lvl++;
         end
         return lvl;
      endfunction

      // returns the number of selections the item should cause
      function int predict_run(req_type item);
         rsp_type run[$];
         rsp_type sel;
         logic [4:0] lvl;
         logic [4:0] group;
         acl_type target;
         lvl = level_of(item.brightness);
         if (lvl == applied_level && !item.force_update) return 0;
         sel.last_of_run = 1'b0;
         sel.table_kind = gamma_curve ? KIND_GAMMA19 : KIND_GAMMA22;
         sel.table_index = lvl;
         run.push_back(sel);
         applied_level = lvl;
         if (acl_en) group = (lvl <= ELVSS_ACL_LOW_MAX) ? 5'd0 : 5'd1;
         else if (lvl <= ELVSS_GRP0_MAX) group = 5'd0;
         else if (lvl <= ELVSS_GRP1_MAX) group = 5'd1;
         else if (lvl <= ELVSS_GRP2_MAX) group = 5'd2;
         else group = 5'd3;
         sel.table_kind = KIND_ELVSS;
         sel.table_index = group;
         run.push_back(sel);
         if (acl_en) begin
            if (acl_state == ACL_OFF) begin
               sel.table_kind = (lvl <= ACL_OFF_MAX) ? KIND_ACL_STEP : KIND_ACL_ON;
               sel.table_index = '0;
               run.push_back(sel);
            end
            if (lvl <= ACL_OFF_MAX) target = ACL_OFF;
            else if (lvl <= ACL_FORTY_MAX) target = ACL_FORTY;
            else target = ACL_FIFTY;
            if (acl_state != target) begin
               sel.table_kind = KIND_ACL_STEP;
               sel.table_index = 5'(target);
               run.push_back(sel);
               acl_state = target;
            end
         end else begin
            sel.table_kind = KIND_ACL_STEP;
            sel.table_index = 5'(ACL_OFF);
            run.push_back(sel);
            acl_state = ACL_OFF;
         end
         run[run.size()-1].last_of_run = 1'b1;
         foreach (run[i]) expected_selections.push_back(run[i]);
         return run.size();
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_selection(rsp_type got);
         rsp_type want;
         if (expected_selections.size() == 0) begin
            report($sformatf("unexpected selection kind %0d index %0d last %0b",
                             got.table_kind, got.table_index, got.last_of_run));
            return;
         end
         want = expected_selections.pop_front();
         if (got.table_kind !== want.table_kind)
            report($sformatf("table_kind %0d, expected %0d",
                             got.table_kind, want.table_kind));
         if (got.table_index !== want.table_index)
            report($sformatf("table_index %0d, expected %0d (kind %0d)",
                             got.table_index, want.table_index, want.table_kind));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                             got.last_of_run, want.last_of_run, want.table_kind));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic csr_wr_data;

   selection_checker board = new();
   bit idle_off = 1'b0;
   int rsp_hold = 0;
   int cycle_count = 0;

   panel_dimming_level_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int draw_gap();
      return idle_off ? 0 : $urandom_range(0, 6);
   endfunction

   // result side: after each selection, stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         board.check_selection(rsp_payload);
         rsp_hold = draw_gap();
         rsp_stall <= (rsp_hold > 0);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_stall <= 1'b0;
      end
   end

   // called at a rising edge; leaves req_valid high for the caller
   task automatic send_request(input req_type item, output int n_sel);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sel = board.predict_run(item);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_selections.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(posedge clock);
      board.set_register(index, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0] plain_bright [15] = '{8'd114, 8'd114, 8'd0, 8'd255, 8'd29, 8'd30, 8'd250,
                                        8'd251, 8'd251, 8'd64, 8'd65, 8'd122, 8'd123,
                                        8'd162, 8'd163};
      logic [14:0] plain_forced = 15'b000000100000010;
      logic [7:0] acl_bright [8] = '{8'd0, 8'd30, 8'd35, 8'd210, 8'd211, 8'd211, 8'd0,
                                     8'd152};
      logic [7:0] acl_forced = 8'b00100000;
      req_type item;
      logic [7:0] prev_bright;
      int n_sel;
      int produced;
      int roll;
      int waited;
      logic gc;
      logic ae;

      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // boundaries, forced repeats and every ELVSS group with ACL off
      foreach (plain_bright[i]) begin
         item.brightness = plain_bright[i];
         item.force_update = plain_forced[14-i];
         send_request(item, n_sel);
      end
      settle();
      write_csr(CSR_GAMMA_CURVE, 1'b1);
      write_csr(CSR_ACL_EN, 1'b1);
      write_csr(CSR_SPARE, 1'b1);

      // ACL step transitions off, forty, fifty and back
      foreach (acl_bright[i]) begin
         item.brightness = acl_bright[i];
         item.force_update = acl_forced[7-i];
         send_request(item, n_sel);
      end
      prev_bright = item.brightness;

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         if (phase < 4) begin
            gc = phase[0];
            ae = phase[1];
         end else begin
            gc = 1'($urandom_range(0, 1));
            ae = 1'($urandom_range(0, 1));
         end
         write_csr(CSR_GAMMA_CURVE, gc);
         write_csr(CSR_ACL_EN, ae);
         if (phase == 4) write_csr(CSR_RESERVED, 1'($urandom_range(0, 1)));
         produced = 0;
         while (produced < 46) begin
            if ($urandom_range(0, 29) == 0) idle_off = !idle_off;
            roll = $urandom_range(0, 9);
            if (roll < 4)
               item.brightness = 8'($urandom_range(0, 255));
            else if (roll < 7)
               item.brightness = 8'(LEVEL_FLOOR[$urandom_range(0, NUM_LEVELS-2)]
                                    - $urandom_range(0, 1));
            else if (roll < 9)
               item.brightness = prev_bright;
            else
               item.brightness = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            item.force_update = ($urandom_range(0, 3) == 0);
            send_request(item, n_sel);
            prev_bright = item.brightness;
            if (n_sel > 0) produced++;
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (board.expected_selections.size() > 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (board.expected_selections.size() > 0)
         board.report($sformatf("%0d selections never arrived",
                                board.expected_selections.size()));
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
